// ===== src/tcm_pkg.sv =====
// Shared types, register indexes and sizing constants for the touch coordinate mapper.
package tcm_pkg;

   // Screen geometry in pixels.
   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 240;
   localparam int MAX_SIZE      = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;

   // Raw sample and field widths.
   localparam int RAW_W   = 12;
   localparam int SCR_X_W = 9;
   localparam int SCR_Y_W = 8;

   // Width of the scaled numerator magnitude, which is also the quotient width.
   localparam int NUM_W = $clog2(((1 << RAW_W) - 1) * MAX_SIZE + 1);

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = RAW_W;

   localparam logic [CSR_IDX_W-1:0] CSR_PRESSURE_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_AXES          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_RAW_MIN          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_X_RAW_MAX          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_RAW_MIN          = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_RAW_MAX          = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR_HORIZONTAL  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MIRROR_VERTICAL    = 3'd7;

   // Input beat.
   typedef struct packed {
      logic [RAW_W-1:0] sample_x;
      logic [RAW_W-1:0] sample_y;
      logic [RAW_W-1:0] sample_pressure;
   } tcm_req_type;

   // Result beat.
   typedef struct packed {
      logic               touched;
      logic [SCR_X_W-1:0] screen_x;
      logic [SCR_Y_W-1:0] screen_y;
      logic               calibration_fault;
   } tcm_rsp_type;

   // Configuration registers.
   typedef struct packed {
      logic [RAW_W-1:0] pressure_threshold;
      logic             swap_axes;
      logic [RAW_W-1:0] x_raw_min;
      logic [RAW_W-1:0] x_raw_max;
      logic [RAW_W-1:0] y_raw_min;
      logic [RAW_W-1:0] y_raw_max;
      logic             mirror_horizontal;
      logic             mirror_vertical;
   } tcm_cfg_type;

   // One axis in flight through the divider chain.
   typedef struct packed {
      logic             neg;   // numerator and span have opposite signs
      logic [RAW_W-1:0] den;   // span magnitude
      logic [RAW_W-1:0] rem;   // partial remainder
      logic [NUM_W-1:0] work;  // numerator bits shifting out, quotient bits shifting in
   } tcm_lane_type;

   // One stage of the pipeline.
   typedef struct packed {
      logic         valid;
      logic         touched;
      logic         fault;
      tcm_lane_type lane_x;
      tcm_lane_type lane_y;
   } tcm_stage_type;

endpackage

// ===== src/tcm_front.sv =====
// Front stage: pressure and span checks, axis swap, offset and scaling of both axes.
module tcm_front
   import tcm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  tcm_req_type   req_data,
   input  tcm_cfg_type   cfg,
   output tcm_stage_type stage_out
);

   tcm_stage_type    stage_ff;
   tcm_stage_type    stage_in;
   logic [RAW_W-1:0] raw_x;
   logic [RAW_W-1:0] raw_y;
   logic [RAW_W:0]   diff_x;
   logic [RAW_W:0]   diff_y;
   logic [RAW_W:0]   span_x;
   logic [RAW_W:0]   span_y;
   logic [RAW_W-1:0] mag_x;
   logic [RAW_W-1:0] mag_y;

   // Signed offsets and spans, held one bit wider than the raw values.
   always_comb begin
      raw_x  = cfg.swap_axes ? req_data.sample_y : req_data.sample_x;
      raw_y  = cfg.swap_axes ? req_data.sample_x : req_data.sample_y;
      diff_x = {1'b0, raw_x} - {1'b0, cfg.x_raw_min};
      diff_y = {1'b0, raw_y} - {1'b0, cfg.y_raw_min};
      span_x = {1'b0, cfg.x_raw_max} - {1'b0, cfg.x_raw_min};
      span_y = {1'b0, cfg.y_raw_max} - {1'b0, cfg.y_raw_min};
      mag_x  = diff_x[RAW_W] ? RAW_W'(-diff_x) : diff_x[RAW_W-1:0];
      mag_y  = diff_y[RAW_W] ? RAW_W'(-diff_y) : diff_y[RAW_W-1:0];
   end

   // Build the first stage: flags, span magnitudes and scaled numerators.
   always_comb begin
      stage_in.valid       = accept;
      stage_in.fault       = (cfg.x_raw_max == cfg.x_raw_min) ||
                             (cfg.y_raw_max == cfg.y_raw_min);
      stage_in.touched     = !stage_in.fault &&
                             (req_data.sample_pressure >= cfg.pressure_threshold);
      stage_in.lane_x.neg  = diff_x[RAW_W] ^ span_x[RAW_W];
      stage_in.lane_x.den  = span_x[RAW_W] ? RAW_W'(-span_x) : span_x[RAW_W-1:0];
      stage_in.lane_x.rem  = '0;
      stage_in.lane_x.work = NUM_W'(mag_x) * NUM_W'(SCREEN_WIDTH);
      stage_in.lane_y.neg  = diff_y[RAW_W] ^ span_y[RAW_W];
      stage_in.lane_y.den  = span_y[RAW_W] ? RAW_W'(-span_y) : span_y[RAW_W-1:0];
      stage_in.lane_y.rem  = '0;
      stage_in.lane_y.work = NUM_W'(mag_y) * NUM_W'(SCREEN_HEIGHT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

// ===== src/tcm_div_cell.sv =====
// Divider cell: one restoring division step for each axis, registered.
module tcm_div_cell
   import tcm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  tcm_stage_type stage_in,
   output tcm_stage_type stage_out
);

   tcm_stage_type stage_ff;
   tcm_stage_type stage_nx;

   // Shift the next numerator bit into the remainder and subtract the span if it fits.
   function automatic tcm_lane_type div_step(input tcm_lane_type lane);
      tcm_lane_type   res;
      logic [RAW_W:0] shifted;
      logic           fits;
      shifted  = {lane.rem, lane.work[NUM_W-1]};
      fits     = shifted >= {1'b0, lane.den};
      res      = lane;
      res.rem  = fits ? RAW_W'(shifted - {1'b0, lane.den}) : shifted[RAW_W-1:0];
      res.work = {lane.work[NUM_W-2:0], fits};
      return res;
   endfunction

   always_comb begin
      stage_nx        = stage_in;
      stage_nx.lane_x = div_step(stage_in.lane_x);
      stage_nx.lane_y = div_step(stage_in.lane_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_nx;
      end
   end

   assign stage_out = stage_ff;

endmodule

// ===== src/tcm_back.sv =====
// Back stage: clamp, mirror and register the result beat.
module tcm_back
   import tcm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  tcm_stage_type stage_in,
   input  tcm_cfg_type   cfg,
   output logic          rsp_valid,
   output tcm_rsp_type   rsp_data
);

   localparam logic [NUM_W-1:0] LAST_X = NUM_W'(SCREEN_WIDTH - 1);
   localparam logic [NUM_W-1:0] LAST_Y = NUM_W'(SCREEN_HEIGHT - 1);

   logic             valid_ff;
   tcm_rsp_type      rsp_ff;
   tcm_rsp_type      rsp_in;
   logic [NUM_W-1:0] clamp_x;
   logic [NUM_W-1:0] clamp_y;
   logic [NUM_W-1:0] pos_x;
   logic [NUM_W-1:0] pos_y;

   // A negative quotient clamps to zero, an oversized one to the last pixel.
   always_comb begin
      if (stage_in.lane_x.neg) begin
         clamp_x = '0;
      end else if (stage_in.lane_x.work > LAST_X) begin
         clamp_x = LAST_X;
      end else begin
         clamp_x = stage_in.lane_x.work;
      end
      if (stage_in.lane_y.neg) begin
         clamp_y = '0;
      end else if (stage_in.lane_y.work > LAST_Y) begin
         clamp_y = LAST_Y;
      end else begin
         clamp_y = stage_in.lane_y.work;
      end
      pos_x = cfg.mirror_horizontal ? (LAST_X - clamp_x) : clamp_x;
      pos_y = cfg.mirror_vertical ? (LAST_Y - clamp_y) : clamp_y;
   end

   // Coordinates read as zero when there is no touch.
   always_comb begin
      rsp_in.touched           = stage_in.touched;
      rsp_in.screen_x          = stage_in.touched ? pos_x[SCR_X_W-1:0] : '0;
      rsp_in.screen_y          = stage_in.touched ? pos_y[SCR_Y_W-1:0] : '0;
      rsp_in.calibration_fault = stage_in.fault;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/touch_coordinate_mapper_unit.sv =====
// Top level of the touch coordinate mapper: registers, front stage, divider chain, back stage.
//
// One raw touch sample enters per clock whenever start is high; busy never rises, so a sample
// may follow in every cycle. Its result leaves as a one-cycle rsp_valid strobe with the beat
// on rsp_data, in the order the samples came in. Each sample passes through the scaling
// stage in front, the divider chain (one cell per quotient bit, each cell doing one restore
// step for both axes) and the clamp and mirror stage behind. The receiver must take every
// beat in the cycle it appears.
// Calibration registers are to be written only while no sample is in flight.
module touch_coordinate_mapper_unit
   import tcm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tcm_req_type           req_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   output tcm_rsp_type           rsp_data
);

   tcm_cfg_type   cfg_ff;
   tcm_stage_type stage [NUM_W+1];

   // Calibration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pressure_threshold <= '0;
         cfg_ff.swap_axes          <= 1'b0;
         cfg_ff.x_raw_min          <= '0;
         cfg_ff.x_raw_max          <= '1;
         cfg_ff.y_raw_min          <= '0;
         cfg_ff.y_raw_max          <= '1;
         cfg_ff.mirror_horizontal  <= 1'b0;
         cfg_ff.mirror_vertical    <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PRESSURE_THRESHOLD: cfg_ff.pressure_threshold <= csr_wdata;
            CSR_SWAP_AXES:          cfg_ff.swap_axes          <= csr_wdata[0];
            CSR_X_RAW_MIN:          cfg_ff.x_raw_min          <= csr_wdata;
            CSR_X_RAW_MAX:          cfg_ff.x_raw_max          <= csr_wdata;
            CSR_Y_RAW_MIN:          cfg_ff.y_raw_min          <= csr_wdata;
            CSR_Y_RAW_MAX:          cfg_ff.y_raw_max          <= csr_wdata;
            CSR_MIRROR_HORIZONTAL:  cfg_ff.mirror_horizontal  <= csr_wdata[0];
            CSR_MIRROR_VERTICAL:    cfg_ff.mirror_vertical    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // The pipeline never stalls.
   assign busy = 1'b0;

   tcm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (start && !busy),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .stage_out (stage[0])
   );

   // Divider chain: one cell per quotient bit, most significant first.
   for (genvar i = 0; i < NUM_W; i++) begin : g_cell
      tcm_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (stage[i]),
         .stage_out (stage[i+1])
      );
   end

   tcm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .stage_in  (stage[NUM_W]),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the touch coordinate mapper: directed and random samples.
module tb_top;
   import tcm_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PERCENT = 36;
   localparam int PIPE_DEPTH   = NUM_W + 2;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   tcm_req_type req_data = '0;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_PRESSURE_THRESHOLD;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic rsp_valid;
   tcm_rsp_type rsp_data;

   // Samples waiting to be sent and mapped points waiting to come back.
   tcm_req_type pending_samples[$];
   tcm_rsp_type expected_points[$];
   tcm_cfg_type shadow_cfg;
   bit steady_send = 1'b0;
   int error_count = 0;
   int cycle_count = 0;

   touch_coordinate_mapper_unit uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Linear mapping of one axis with truncating division, clamp to the screen and mirror.
   function automatic int scale_axis(int raw, int lo, int hi, int size, bit flip);
      int num;
      int den;
      int v;
      num = (raw - lo) * size;
      den = hi - lo;
      v = num / den;
      if (v < 0) v = 0;
      if (v >= size) v = size - 1;
      if (flip) v = (size - 1) - v;
      return v;
   endfunction

   // Expected result beat for one sample under the given calibration.
   function automatic tcm_rsp_type predict_touch(tcm_cfg_type c, tcm_req_type s);
      tcm_rsp_type r;
      logic [RAW_W-1:0] ax;
      logic [RAW_W-1:0] ay;
      int vx;
      int vy;
      r = '0;
      r.calibration_fault = (c.x_raw_max == c.x_raw_min) || (c.y_raw_max == c.y_raw_min);
      if (!r.calibration_fault && s.sample_pressure >= c.pressure_threshold) begin
         ax = c.swap_axes ? s.sample_y : s.sample_x;
         ay = c.swap_axes ? s.sample_x : s.sample_y;
         vx = scale_axis(int'(ax), int'(c.x_raw_min), int'(c.x_raw_max), SCREEN_WIDTH,
                         c.mirror_horizontal);
         vy = scale_axis(int'(ay), int'(c.y_raw_min), int'(c.y_raw_max), SCREEN_HEIGHT,
                         c.mirror_vertical);
         r.touched  = 1'b1;
         r.screen_x = vx[SCR_X_W-1:0];
         r.screen_y = vy[SCR_Y_W-1:0];
      end
      return r;
   endfunction

   // Driver: records the expectation of each accepted beat and offers the next sample.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_points.push_back(predict_touch(shadow_cfg, req_data));
         end
         if (start && busy) begin
            // The offered beat has not been taken yet, so it stays on the port.
         end else if (pending_samples.size() != 0 &&
                      (steady_send || $urandom_range(99) >= IDLE_PERCENT)) begin
            start    <= 1'b1;
            req_data <= pending_samples.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Monitor: every strobed beat is compared with the oldest expectation.
   always @(posedge clock) begin : monitor_proc
      tcm_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_points.size() == 0) begin
            error_count++;
            $display("%0t: unexpected beat, expected none, actual %h", $time, rsp_data);
         end else begin
            want = expected_points.pop_front();
            check_field("touched", int'(want.touched), int'(rsp_data.touched));
            check_field("screen_x", int'(want.screen_x), int'(rsp_data.screen_x));
            check_field("screen_y", int'(want.screen_y), int'(rsp_data.screen_y));
            check_field("calibration_fault", int'(want.calibration_fault),
                        int'(rsp_data.calibration_fault));
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d beats outstanding", $time, expected_points.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Mirrors a register write into the local copy of the calibration.
   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_PRESSURE_THRESHOLD: shadow_cfg.pressure_threshold = data;
         CSR_SWAP_AXES:          shadow_cfg.swap_axes          = data[0];
         CSR_X_RAW_MIN:          shadow_cfg.x_raw_min          = data;
         CSR_X_RAW_MAX:          shadow_cfg.x_raw_max          = data;
         CSR_Y_RAW_MIN:          shadow_cfg.y_raw_min          = data;
         CSR_Y_RAW_MAX:          shadow_cfg.y_raw_max          = data;
         CSR_MIRROR_HORIZONTAL:  shadow_cfg.mirror_horizontal  = data[0];
         CSR_MIRROR_VERTICAL:    shadow_cfg.mirror_vertical    = data[0];
         default: ;
      endcase
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      apply_reg(idx, data);
   endtask

   task automatic queue_sample(int x, int y, int p);
      tcm_req_type s;
      s.sample_x        = x[RAW_W-1:0];
      s.sample_y        = y[RAW_W-1:0];
      s.sample_pressure = p[RAW_W-1:0];
      pending_samples.push_back(s);
   endtask

   // Waits until every queued sample has been taken and every result has come back.
   task automatic drain;
      @(negedge clock);
      while (pending_samples.size() != 0 || expected_points.size() != 0 || start)
         @(negedge clock);
   endtask

   // Picks a calibration span for one axis, now and then a degenerate one.
   task automatic pick_span(output int lo, output int hi);
      int mode;
      mode = $urandom_range(9);
      if (mode <= 3) begin
         lo = $urandom_range(600, 100);
         hi = $urandom_range(4000, 3500);
      end else if (mode <= 5) begin
         lo = $urandom_range(4000, 3500);
         hi = $urandom_range(600, 100);
      end else if (mode <= 7) begin
         lo = $urandom_range(4095);
         hi = $urandom_range(4095);
      end else if (mode == 8) begin
         lo = $urandom_range(1) ? 4095 : 0;
         hi = 4095 - lo;
      end else begin
         lo = $urandom_range(4095);
         hi = lo;
      end
   endtask

   initial begin : stimulus_proc
      int thr;
      int lo;
      int hi;
      int n_items;
      int sel;
      shadow_cfg = '{pressure_threshold: '0, swap_axes: 1'b0, x_raw_min: '0,
                     x_raw_max: 12'd4095, y_raw_min: '0, y_raw_max: 12'd4095,
                     mirror_horizontal: 1'b0, mirror_vertical: 1'b0};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset calibration: field extremes and zero pressure against a zero threshold.
      queue_sample(0, 0, 0);
      queue_sample(4095, 4095, 4095);
      queue_sample(4095, 0, 1);
      queue_sample(0, 4095, 2048);
      queue_sample(2048, 2048, 0);
      drain();

      // Highest threshold with swapped and mirrored axes.
      write_reg(CSR_PRESSURE_THRESHOLD, 12'd4095);
      write_reg(CSR_SWAP_AXES, 12'd1);
      write_reg(CSR_MIRROR_HORIZONTAL, 12'd1);
      write_reg(CSR_MIRROR_VERTICAL, 12'd1);
      queue_sample(1234, 3210, 4094);
      queue_sample(1234, 3210, 4095);
      queue_sample(100, 3000, 4095);
      drain();

      // Inverted spans on both axes, pressure just either side of the threshold.
      write_reg(CSR_PRESSURE_THRESHOLD, 12'd100);
      write_reg(CSR_SWAP_AXES, 12'd0);
      write_reg(CSR_MIRROR_HORIZONTAL, 12'd0);
      write_reg(CSR_MIRROR_VERTICAL, 12'd0);
      write_reg(CSR_X_RAW_MIN, 12'd4095);
      write_reg(CSR_X_RAW_MAX, 12'd0);
      write_reg(CSR_Y_RAW_MIN, 12'd3900);
      write_reg(CSR_Y_RAW_MAX, 12'd200);
      queue_sample(0, 0, 100);
      queue_sample(4095, 4095, 99);
      queue_sample(2000, 100, 4095);
      queue_sample(4000, 3950, 500);
      drain();

      // Zero span on x, then on y only: the fault shows at any pressure.
      write_reg(CSR_X_RAW_MAX, 12'd4095);
      queue_sample(1000, 1000, 4095);
      queue_sample(0, 0, 0);
      drain();
      write_reg(CSR_X_RAW_MAX, 12'd0);
      write_reg(CSR_Y_RAW_MAX, 12'd3900);
      queue_sample(2000, 2000, 4095);
      queue_sample(2000, 2000, 5);
      drain();

      // Narrow window so that both clamps are reached, with mirroring.
      write_reg(CSR_X_RAW_MIN, 12'd1000);
      write_reg(CSR_X_RAW_MAX, 12'd3000);
      write_reg(CSR_Y_RAW_MIN, 12'd500);
      write_reg(CSR_Y_RAW_MAX, 12'd3500);
      write_reg(CSR_MIRROR_HORIZONTAL, 12'd1);
      write_reg(CSR_MIRROR_VERTICAL, 12'd1);
      queue_sample(0, 0, 4095);
      queue_sample(4095, 4095, 4095);
      queue_sample(3000, 3500, 4095);
      queue_sample(1000, 500, 4095);
      drain();

      // Random calibrations, each followed by a batch of random samples.
      for (int phase = 0; phase < 17; phase++) begin
         sel = $urandom_range(7);
         thr = (sel == 0) ? 0 : (sel == 1) ? 4095 : $urandom_range(3000);
         write_reg(CSR_PRESSURE_THRESHOLD, thr[RAW_W-1:0]);
         write_reg(CSR_SWAP_AXES, RAW_W'($urandom_range(4095)));
         write_reg(CSR_MIRROR_HORIZONTAL, RAW_W'($urandom_range(4095)));
         write_reg(CSR_MIRROR_VERTICAL, RAW_W'($urandom_range(4095)));
         pick_span(lo, hi);
         write_reg(CSR_X_RAW_MIN, lo[RAW_W-1:0]);
         write_reg(CSR_X_RAW_MAX, hi[RAW_W-1:0]);
         pick_span(lo, hi);
         write_reg(CSR_Y_RAW_MIN, lo[RAW_W-1:0]);
         write_reg(CSR_Y_RAW_MAX, hi[RAW_W-1:0]);
         // One long batch goes out back to back with no idle cycles.
         steady_send = (phase == 5);
         n_items = steady_send ? 300 : 65;
         for (int i = 0; i < n_items; i++) begin
            sel = $urandom_range(9);
            if (sel < 5)
               queue_sample($urandom_range(4095), $urandom_range(4095),
                            $urandom_range(4095, thr));
            else if (sel < 8)
               queue_sample($urandom_range(4095), $urandom_range(4095), $urandom_range(4095));
            else
               queue_sample($urandom_range(4095), $urandom_range(4095),
                            (thr == 0) ? $urandom_range(1) : thr - 1 + $urandom_range(2));
         end
         drain();
         steady_send = 1'b0;
      end

      // Let the pipeline settle past its depth before the verdict.
      repeat (PIPE_DEPTH + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/tcm_pkg.sv
src/tcm_front.sv
src/tcm_div_cell.sv
src/tcm_back.sv
src/touch_coordinate_mapper_unit.sv
tb/tb_top.sv
